### hdl/mtfc_pkg.sv
`timescale 1ns / 1ps
// Package for the move-to-front coder: widths, defaults, register indexes,
// the controller state type and the structs passed along the cell chain.
// No dependencies.
package mtfc_pkg;

   localparam int SYM_W               = 8;
   localparam int DEFAULT_NUM_SYMBOLS = 256;
   localparam int CSR_ADDR_W          = 3;
   localparam int CSR_DATA_W          = 32;
   localparam int CSR_IDX_W           = CSR_ADDR_W - 2;

   localparam logic [CSR_IDX_W-1:0] REG_DECODE_MODE = CSR_IDX_W'(0);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_START,
      ST_WALK,
      ST_HOLD
   } state_type;

   typedef struct packed {
      logic             valid;
      logic             done;
      logic [SYM_W-1:0] carry;
      logic [SYM_W-1:0] result;
   } token_type;

   typedef struct packed {
      logic             restore;
      logic             decode_mode;
      logic [SYM_W-1:0] key;
   } cell_ctrl_type;

endpackage

### hdl/mtfc_req_if.sv
`timescale 1ns / 1ps
// Input channel of the move-to-front coder: one symbol or rank per word.
// Depends on mtfc_pkg.
interface mtfc_req_if
   import mtfc_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic [SYM_W-1:0] symbol_in;
   logic             block_start;

   modport source (output valid, output symbol_in, output block_start, input ready);
   modport sink   (input valid, input symbol_in, input block_start, output ready);
endinterface

### hdl/mtfc_rsp_if.sv
`timescale 1ns / 1ps
// Result channel of the move-to-front coder: one rank or symbol per word.
// Depends on mtfc_pkg.
interface mtfc_rsp_if
   import mtfc_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic [SYM_W-1:0] symbol_out;

   modport source (output valid, output symbol_out, input ready);
   modport sink   (input valid, input symbol_out, output ready);
endinterface

### hdl/mtfc_cell.sv
`timescale 1ns / 1ps
// One cell of the recency chain: holds the list entry at a fixed position
// and hands the travelling token to its neighbor. Depends on mtfc_pkg.
module mtfc_cell
   import mtfc_pkg::*;
#(
   parameter int INDEX = 0
) (
   input  logic             clock,
   input  logic             reset,
   input  cell_ctrl_type    ctrl,
   input  logic             front_we,
   input  logic [SYM_W-1:0] front_val,
   input  token_type        tok_in,
   output token_type        tok_out
);

   localparam logic [SYM_W-1:0] POS = SYM_W'(INDEX);

   logic [SYM_W-1:0] entry_ff;
   logic [SYM_W-1:0] entry_in;
   token_type        tok_ff;
   token_type        tok_in_next;
   logic             active;
   logic             match;

   assign active = tok_in.valid && !tok_in.done;
   assign match  = ctrl.decode_mode ? (ctrl.key == POS) : (entry_ff == ctrl.key);

   always_comb begin
      priority if (ctrl.restore) begin
         entry_in = POS;
      end else if (front_we) begin
         entry_in = front_val;
      end else if (active) begin
         entry_in = tok_in.carry;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_comb begin
      tok_in_next.valid  = tok_in.valid;
      tok_in_next.done   = tok_in.done || match;
      tok_in_next.carry  = entry_ff;
      tok_in_next.result = tok_in.result;
      if (active && match) begin
         tok_in_next.result = ctrl.decode_mode ? entry_ff : POS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff     <= POS;
         tok_ff.valid <= 1'b0;
      end else begin
         entry_ff <= entry_in;
         tok_ff   <= tok_in_next;
      end
   end

   assign tok_out = tok_ff;

endmodule

### hdl/mtfc_ctrl.sv
`timescale 1ns / 1ps
// Controller of the move-to-front coder: mode register, input handshake,
// token launch, front update and the output register. Depends on mtfc_pkg.
module mtfc_ctrl
   import mtfc_pkg::*;
#(
   parameter int NUM_SYMBOLS = DEFAULT_NUM_SYMBOLS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [SYM_W-1:0]      req_symbol,
   input  logic                  req_block_start,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [SYM_W-1:0]      rsp_symbol,
   output cell_ctrl_type         cell_ctrl,
   output logic                  front_we,
   output logic [SYM_W-1:0]      front_val,
   output token_type             tok_first,
   input  token_type             tok_last
);

   localparam logic [SYM_W:0] LIMIT = (SYM_W+1)'(NUM_SYMBOLS);

   state_type        state_ff, state_in;
   logic             mode_ff, mode_in;
   logic [SYM_W-1:0] key_ff, key_in;
   logic [SYM_W-1:0] result_ff, result_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [SYM_W-1:0] rsp_data_ff, rsp_data_in;
   logic             accept;
   logic             in_range;
   logic             rsp_free;
   logic             csr_hit;

   assign csr_hit    = csr_paddr[CSR_ADDR_W-1:2] == REG_DECODE_MODE;
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_hit ? CSR_DATA_W'(mode_ff) : '0;
   assign mode_in    = (csr_psel && csr_penable && csr_pwrite && csr_hit) ?
                       csr_pwdata[0] : mode_ff;

   assign accept   = req_valid && req_ready;
   assign in_range = {1'b0, req_symbol} < LIMIT;
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_valid) state_in = in_range ? ST_START : ST_HOLD;
         ST_START: state_in = ST_WALK;
         ST_WALK:  if (tok_last.valid) state_in = ST_HOLD;
         ST_HOLD:  if (rsp_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      tok_first    = '0;
      front_we     = 1'b0;
      front_val    = mode_ff ? tok_last.result : key_ff;
      key_in       = key_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            key_in    = req_symbol;
            result_in = req_symbol;
         end
         ST_START: begin
            tok_first.valid = 1'b1;
         end
         ST_WALK: begin
            if (tok_last.valid) begin
               front_we  = 1'b1;
               result_in = tok_last.result;
            end
         end
         ST_HOLD: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = result_ff;
            end
         end
         default: ;
      endcase
   end

   assign cell_ctrl.restore     = accept && req_block_start;
   assign cell_ctrl.decode_mode = mode_ff;
   assign cell_ctrl.key         = key_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff      <= key_in;
      result_ff   <= result_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_symbol = rsp_data_ff;

endmodule

### hdl/move_to_front_coder.sv
`timescale 1ns / 1ps
// Top level of the byte-wide move-to-front coder: controller plus a chain of
// NUM_SYMBOLS list cells. Depends on mtfc_pkg, mtfc_req_if, mtfc_rsp_if,
// mtfc_ctrl and mtfc_cell.
//
//   Channel   Direction   Handshake               Word
//   req_ch    in          valid/ready             symbol_in, block_start
//   rsp_ch    out         valid/ready             symbol_out
//   csr_*     in          APB write, pready = 1   decode_mode at address 0
//
// From acceptance a word goes through the start state, the token's walk once
// through every cell of the chain and the hold state, which waits until the
// output register is free; a symbol or rank outside the alphabet skips the
// chain. The next word is accepted in the cycle after the result is loaded.
// Reset is synchronous and loads the identity list into the cells.
// A finished word waits in the output register while the next word is walked;
// a second finished word waits in the controller until the first is taken.
module move_to_front_coder
   import mtfc_pkg::*;
#(
   parameter int NUM_SYMBOLS = DEFAULT_NUM_SYMBOLS
) (
   input  logic                  clock,
   input  logic                  reset,
   mtfc_req_if.sink              req_ch,
   mtfc_rsp_if.source            rsp_ch,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cell_ctrl_type    cell_ctrl;
   logic             front_we;
   logic [SYM_W-1:0] front_val;
   token_type        tok [NUM_SYMBOLS+1];

   mtfc_ctrl #(
      .NUM_SYMBOLS (NUM_SYMBOLS)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready),
      .req_valid       (req_ch.valid),
      .req_ready       (req_ch.ready),
      .req_symbol      (req_ch.symbol_in),
      .req_block_start (req_ch.block_start),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ready       (rsp_ch.ready),
      .rsp_symbol      (rsp_ch.symbol_out),
      .cell_ctrl       (cell_ctrl),
      .front_we        (front_we),
      .front_val       (front_val),
      .tok_first       (tok[0]),
      .tok_last        (tok[NUM_SYMBOLS])
   );

   for (genvar k = 0; k < NUM_SYMBOLS; k++) begin : g_cell
      if (k == 0) begin : g_front
         mtfc_cell #(
            .INDEX (k)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctrl      (cell_ctrl),
            .front_we  (front_we),
            .front_val (front_val),
            .tok_in    (tok[k]),
            .tok_out   (tok[k+1])
         );
      end else begin : g_body
         mtfc_cell #(
            .INDEX (k)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctrl      (cell_ctrl),
            .front_we  (1'b0),
            .front_val (front_val),
            .tok_in    (tok[k]),
            .tok_out   (tok[k+1])
         );
      end
   end

endmodule
